/* hdl/tcw_pkg.sv */
// Package for the text console writer: geometry constants, command and
// character codes, and the item and result types shared by the RTL.
// No dependencies.
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;

  // field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(COLUMNS * ROWS);
  localparam int TAB_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  // stream payload widths (padded to whole bytes)
  localparam int IN_FIELDS_W   = CHAR_W + COL_W + ROW_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W    = CMD_W;
  localparam int OUT_FIELDS_W  = ADDR_W + CHAR_W + ATTR_W + ROW_W + ROW_W + COL_W + ROW_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W   = 3;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR     = 2'd0,
    CMD_SET_CURSOR   = 2'd1,
    CMD_CLEAR_SCREEN = 2'd2
  } cmd_e;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // one accepted command
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] character;
    logic [CMD_W-1:0]  command;
  } item_t;

  // one result
  typedef struct packed {
    logic              last;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  top_row;
    logic              clear_all;
    logic [ROW_W-1:0]  cleared_row;
    logic              clear_row;
    logic [ATTR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
    logic [ADDR_W-1:0] cell_address;
    logic              cell_write;
  } result_t;

endpackage

`default_nettype wire

/* hdl/text_console_writer.sv */
// A command is held in the input register, its result in the result register.
// One command per cycle while the result stream does not stall; a tab holds
// the input register for TAB_WIDTH results (eight), one result per unstalled cycle.
// The cursor, top-row offset and result are computed in one pass
// of logic between the input register and the result register.
// Reset (rst_ni low, asynchronous): cursor, top row and attribute go to zero.
`default_nettype none

module text_console_writer (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // attribute register write
  input  wire                              text_attr_we_i,
  input  wire  [tcw_pkg::ATTR_W-1:0]       text_attr_i,
  // command stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: character[7:0], column[14:8], row[19:15], zero pad
  input  wire  [tcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: command[1:0]
  input  wire  [tcw_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata: cell_address[10:0], cell_char[18:11], cell_attr[26:19],
  //        cleared_row[31:27], top_row[36:32], cursor_col[43:37],
  //        cursor_row[48:44], zero pad
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: cell_write[0], clear_row[1], clear_all[2]
  output logic [tcw_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                             m_axis_tlast
);

  import tcw_pkg::*;

  // registers
  logic [ATTR_W-1:0] text_attr_q;
  logic              in_valid_q;
  item_t             item_q;
  logic [TAB_W-1:0]  tab_cnt_q;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [ROW_W-1:0]  top_q, top_d;
  logic              out_valid_q;
  result_t           res_q, res_d;

  // handshake
  logic out_free, advance, done, accept;

  // datapath helpers
  logic [ROW_W:0]    phys_sum;
  logic [ROW_W-1:0]  phys_row;
  logic [ADDR_W-1:0] row_base;
  logic [COL_W:0]    col_inc;
  logic              row_at_bottom;
  logic [ROW_W-1:0]  top_inc;
  logic              do_print;
  logic [CHAR_W-1:0] print_char;
  logic              do_newline;

  // physical row of the cursor and start address of that row
  always_comb begin
    phys_sum = {1'b0, top_q} + {1'b0, cur_row_q};
    if (phys_sum >= (ROW_W+1)'(ROWS)) begin
      phys_row = ROW_W'(phys_sum - (ROW_W+1)'(ROWS));
    end else begin
      phys_row = phys_sum[ROW_W-1:0];
    end
    row_base      = ADDR_W'(phys_row) * ADDR_W'(COLUMNS);
    col_inc       = {1'b0, cur_col_q} + (COL_W+1)'(1);
    row_at_bottom = (cur_row_q == ROW_W'(ROWS - 1));
    top_inc       = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
  end

  // command decode and next cursor state
  always_comb begin
    res_d      = '0;
    res_d.last = 1'b1;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    top_d      = top_q;
    do_print   = 1'b0;
    print_char = item_q.character;
    do_newline = 1'b0;

    unique case (item_q.command)
      CMD_PUT_CHAR: begin
        if (item_q.character == CH_NEWLINE) begin
          do_newline = 1'b1;
        end else if (item_q.character == CH_BACKSPACE) begin
          if (cur_col_q != '0) begin
            cur_col_d          = cur_col_q - COL_W'(1);
            res_d.cell_write   = 1'b1;
            res_d.cell_address = row_base + ADDR_W'(cur_col_d);
            res_d.cell_char    = '0;
          end
        end else if (item_q.character == CH_TAB) begin
          do_print   = 1'b1;
          print_char = CH_SPACE;
          res_d.last = (tab_cnt_q == TAB_W'(TAB_WIDTH - 1));
        end else begin
          do_print = 1'b1;
        end
      end
      CMD_SET_CURSOR: begin
        cur_col_d = ({1'b0, item_q.column} >= (COL_W+1)'(COLUMNS)) ?
                    COL_W'(COLUMNS - 1) : item_q.column;
        cur_row_d = ({1'b0, item_q.row} >= (ROW_W+1)'(ROWS)) ?
                    ROW_W'(ROWS - 1) : item_q.row;
      end
      CMD_CLEAR_SCREEN: begin
        cur_col_d       = '0;
        cur_row_d       = '0;
        top_d           = '0;
        res_d.clear_all = 1'b1;
      end
      default: begin
      end
    endcase

    // printed character: write cursor cell, advance and wrap
    if (do_print) begin
      res_d.cell_write   = 1'b1;
      res_d.cell_address = row_base + ADDR_W'(cur_col_q);
      res_d.cell_char    = print_char;
      if (col_inc >= (COL_W+1)'(COLUMNS)) begin
        do_newline = 1'b1;
      end else begin
        cur_col_d = col_inc[COL_W-1:0];
      end
    end

    // next line, scrolling at the bottom
    if (do_newline) begin
      cur_col_d = '0;
      if (!row_at_bottom) begin
        cur_row_d = cur_row_q + ROW_W'(1);
      end else begin
        res_d.clear_row   = 1'b1;
        res_d.cleared_row = top_q;
        top_d             = top_inc;
      end
    end

    res_d.cell_attr  = res_d.cell_write ? text_attr_q : '0;
    res_d.top_row    = top_d;
    res_d.cursor_col = cur_col_d;
    res_d.cursor_row = cur_row_d;
  end

  // transaction control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign done          = advance && res_d.last;
  assign s_axis_tready = !in_valid_q || done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= '0;
      in_valid_q  <= 1'b0;
      tab_cnt_q   <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (text_attr_we_i) begin
        text_attr_q <= text_attr_i;
      end
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (done) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        tab_cnt_q <= done ? '0 : tab_cnt_q + TAB_W'(1);
        cur_col_q <= cur_col_d;
        cur_row_q <= cur_row_d;
        top_q     <= top_d;
      end
      if (out_free) begin
        out_valid_q <= advance;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.command   <= s_axis_tuser[CMD_W-1:0];
      item_q.character <= s_axis_tdata[CHAR_W-1:0];
      item_q.column    <= s_axis_tdata[CHAR_W +: COL_W];
      item_q.row       <= s_axis_tdata[CHAR_W+COL_W +: ROW_W];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tuser  = {res_q.clear_all, res_q.clear_row, res_q.cell_write};
  assign m_axis_tdata  = OUT_TDATA_W'({res_q.cursor_row, res_q.cursor_col, res_q.top_row,
                                       res_q.cleared_row, res_q.cell_attr,
                                       res_q.cell_char, res_q.cell_address});

endmodule

`default_nettype wire
